/* rtl/oekf_pkg.sv */
// Package: types, constants and helpers for the odometry EKF prediction step.
package oekf_pkg;

    localparam int CordicStages = 16;
    localparam int CordicRun    = (CordicStages < 24) ? CordicStages : 24;

    localparam logic signed [33:0] AngPi     = 34'sd1686629713;
    localparam logic signed [33:0] AngHalfPi = 34'sd843314857;
    localparam logic signed [33:0] AngTwoPi  = 34'sd3373259426;
    localparam logic signed [31:0] CordicGain = 32'sd652032874;

    localparam logic [1:0] RegVelNoise = 2'd0;
    localparam logic [1:0] RegYawNoise = 2'd1;
    localparam logic [1:0] RegTimeStep = 2'd2;

    typedef struct packed {
        logic signed [15:0] speed;
        logic signed [15:0] pitch;
        logic signed [15:0] turn_rate;
        logic [31:0]        time_tag;
    } t_in_beat;

    typedef struct packed {
        logic signed [23:0] delta_x;
        logic signed [23:0] delta_y;
        logic signed [23:0] heading_step;
        logic signed [31:0] cov_xx;
        logic signed [31:0] cov_xy;
        logic signed [31:0] cov_xh;
        logic signed [31:0] cov_yy;
        logic signed [31:0] cov_yh;
        logic signed [31:0] cov_hh;
        logic [31:0]        tag_out;
    } t_out_beat;

    function automatic logic signed [33:0] atan_at(input int i);
        case (i)
            0: atan_at = 34'sd421657428;
            1: atan_at = 34'sd248918915;
            2: atan_at = 34'sd131521918;
            3: atan_at = 34'sd66762579;
            4: atan_at = 34'sd33510843;
            5: atan_at = 34'sd16771758;
            6: atan_at = 34'sd8387925;
            7: atan_at = 34'sd4194219;
            8: atan_at = 34'sd2097141;
            9: atan_at = 34'sd1048575;
            default: atan_at = 34'sd1 <<< (29 - i);
        endcase
    endfunction

endpackage

/* rtl/odometry_ekf_prediction_step.sv */
// Top level: odometry EKF prediction step with motion increment and covariance.
// One sample enters per clock when the output side keeps up; each result is
// formed by two chained CORDIC pipelines (pitch first, then half and 1.5x
// heading in parallel) and six multiply, round and sum stages whose products
// stay near 32x32 bits. The whole pipe advances only when the output register
// is empty or being taken, so a stall freezes every stage together and nothing
// is lost.
// A zero speed code yields all-zero results but the time tag. Configuration
// writes land immediately and must only be issued while the pipe is empty.
module odometry_ekf_prediction_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  oekf_pkg::t_in_beat   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output oekf_pkg::t_out_beat  o_data,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    localparam int CL  = oekf_pkg::CordicRun + 2; // CORDIC latency
    localparam int L1  = CL;            // pitch cordic done
    localparam int LT  = L1 + CL + 6;   // total pipe depth before output

    logic [15:0] r_vn, r_yn, r_dt;
    logic        adv;
    logic [LT:0] r_v;
    // carry: speed zero flag, tag, turn rate, speed
    logic        r_z  [0:LT];
    logic [31:0] r_tg [0:LT];
    logic signed [15:0] r_yw [0:L1-1];
    logic signed [15:0] r_sp [0:L1-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vn <= 16'd256;
            r_yn <= 16'd256;
            r_dt <= 16'd655;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                oekf_pkg::RegVelNoise: r_vn <= i_cfg_data;
                oekf_pkg::RegYawNoise: r_yn <= i_cfg_data;
                oekf_pkg::RegTimeStep: r_dt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the whole pipe when the output slot frees up.
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[LT-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_z[0]  <= i_data.speed == 16'sd0;
            r_tg[0] <= i_data.time_tag;
            r_yw[0] <= i_data.turn_rate;
            r_sp[0] <= i_data.speed;
            for (int k = 1; k <= LT; k++) begin
                r_z[k]  <= r_z[k-1];
                r_tg[k] <= r_tg[k-1];
            end
            for (int k = 1; k < L1; k++) begin
                r_yw[k] <= r_yw[k-1];
                r_sp[k] <= r_sp[k-1];
            end
        end
    end

    // Pitch cosine: input lands at stage 0, result lines up with index L1-1.
    logic signed [21:0] cp, sp_unused;
    oekf_cordic u_pitch (
        .i_clk(i_clk), .i_en(adv),
        .i_angle(34'(i_data.pitch) <<< 16),
        .o_cos(cp), .o_sin(sp_unused)
    );

    // Stage A (L1): speed*cp, h = turn rate*dt.
    logic signed [37:0] r_a_sc;
    logic signed [33:0] r_a_h;
    // Stage B (L1+1): d = round(sc*dt >> 20), angles.
    logic signed [34:0] r_b_d;
    logic signed [33:0] r_b_h;
    logic signed [55:0] w_scdt;
    logic signed [55:0] w_dr;

    assign w_scdt = 56'(r_a_sc) * $signed({40'd0, r_dt});
    assign w_dr   = (w_scdt + 56'sd524288) >>> 20;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_sc <= 38'(r_sp[L1-1]) * 38'(cp);
            r_a_h  <= 34'(r_yw[L1-1]) * $signed({18'd0, r_dt});
            r_b_d  <= w_dr[34:0];
            r_b_h  <= r_a_h;
        end
    end

    logic signed [33:0] w_half, w_h15;
    assign w_half = r_a_h >>> 1;
    assign w_h15  = r_a_h + w_half;

    logic signed [21:0] ch, sh, c15, s15;
    oekf_cordic u_half (
        .i_clk(i_clk), .i_en(adv), .i_angle(w_half), .o_cos(ch), .o_sin(sh)
    );
    oekf_cordic u_h15 (
        .i_clk(i_clk), .i_en(adv), .i_angle(w_h15), .o_cos(c15), .o_sin(s15)
    );

    // Delay d and h so they meet the heading CORDIC outputs.
    localparam int DD = CL - 2;
    logic signed [34:0] r_dd [0:DD];
    logic signed [33:0] r_hd [0:DD];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dd[0] <= r_b_d;
            r_hd[0] <= r_b_h;
            for (int k = 1; k <= DD; k++) begin
                r_dd[k] <= r_dd[k-1];
                r_hd[k] <= r_hd[k-1];
            end
        end
    end

    logic signed [34:0] d;
    logic signed [33:0] h;
    assign d = r_dd[DD];
    assign h = r_hd[DD];

    // Stage C: products with d, and noise scales.
    logic signed [56:0] r_c_x, r_c_y, r_c_g01, r_c_g11;
    logic signed [33:0] r_c_h;
    logic signed [21:0] r_c_c15, r_c_s15;
    logic signed [32:0] r_c_sa, r_c_sb;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_x   <= 57'(d) * 57'(ch);
            r_c_y   <= 57'(d) * 57'(sh);
            r_c_g01 <= -(57'(d) * 57'(s15));
            r_c_g11 <= -(57'(d) * 57'(c15));
            r_c_h   <= h;
            r_c_c15 <= c15;
            r_c_s15 <= s15;
            r_c_sa  <= $signed({1'b0, 32'(r_vn) * 32'(r_dt)});
            r_c_sb  <= $signed({1'b0, 32'(r_yn) * 32'(r_dt)});
        end
    end

    function automatic logic signed [23:0] sat24(input logic signed [56:0] v);
        if (v > 57'sd8388607) sat24 = 24'sh7FFFFF;
        else if (v < -57'sd8388608) sat24 = 24'sh800000;
        else sat24 = v[23:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) sat32 = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
        else sat32 = v[31:0];
    endfunction

    // Stage D: round outputs, G01 and G11.
    logic signed [23:0] r_d_dx, r_d_dy, r_d_dh;
    logic signed [31:0] r_d_g01, r_d_g11;
    logic signed [21:0] r_d_c15, r_d_s15;
    logic signed [32:0] r_d_sa, r_d_sb;
    logic signed [56:0] w_xr, w_yr, w_g01r, w_g11r;
    logic signed [33:0] w_hr;
    assign w_xr   = (r_c_x + (57'sd1 <<< 27)) >>> 28;
    assign w_yr   = (r_c_y + (57'sd1 <<< 27)) >>> 28;
    assign w_g01r = (r_c_g01 + (57'sd1 <<< 20)) >>> 21;
    assign w_g11r = (r_c_g11 + (57'sd1 <<< 20)) >>> 21;
    assign w_hr   = (r_c_h + 34'sd256) >>> 9;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_dx  <= sat24(w_xr);
            r_d_dy  <= sat24(w_yr);
            r_d_dh  <= w_hr[23:0];
            r_d_g01 <= w_g01r[31:0];
            r_d_g11 <= w_g11r[31:0];
            r_d_c15 <= r_c_c15;
            r_d_s15 <= r_c_s15;
            r_d_sa  <= r_c_sa;
            r_d_sb  <= r_c_sb;
        end
    end

    // Stage E: L products.
    logic signed [55:0] r_e_l00, r_e_l10;
    logic signed [69:0] r_e_l01, r_e_l11;
    logic signed [32:0] r_e_sb;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e_l00 <= 56'(r_d_c15) * 56'(r_d_sa);
            r_e_l10 <= 56'(r_d_s15) * 56'(r_d_sa);
            r_e_l01 <= 70'(r_d_g01) * 70'(r_d_sb);
            r_e_l11 <= 70'(r_d_g11) * 70'(r_d_sb);
            r_e_sb  <= r_d_sb;
        end
    end

    // Stage F: round L entries; each fits in 32 bits.
    logic signed [31:0] r_f_l00, r_f_l10, r_f_l01, r_f_l11, r_f_l21;
    logic signed [55:0] w_l00, w_l10;
    logic signed [69:0] w_l01, w_l11;
    logic signed [32:0] w_l21;
    assign w_l00 = (r_e_l00 + (56'sd1 <<< 27)) >>> 28;
    assign w_l10 = (r_e_l10 + (56'sd1 <<< 27)) >>> 28;
    assign w_l01 = (r_e_l01 + (70'sd1 <<< 31)) >>> 32;
    assign w_l11 = (r_e_l11 + (70'sd1 <<< 31)) >>> 32;
    assign w_l21 = (r_e_sb + 33'sd256) >>> 9;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f_l00 <= w_l00[31:0];
            r_f_l10 <= w_l10[31:0];
            r_f_l01 <= w_l01[31:0];
            r_f_l11 <= w_l11[31:0];
            r_f_l21 <= w_l21[31:0];
        end
    end

    // Stage G: covariance products.
    logic signed [63:0] r_g_p [0:7];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_g_p[0] <= 64'(r_f_l00) * 64'(r_f_l00);
            r_g_p[1] <= 64'(r_f_l01) * 64'(r_f_l01);
            r_g_p[2] <= 64'(r_f_l00) * 64'(r_f_l10);
            r_g_p[3] <= 64'(r_f_l01) * 64'(r_f_l11);
            r_g_p[4] <= 64'(r_f_l01) * 64'(r_f_l21);
            r_g_p[5] <= 64'(r_f_l10) * 64'(r_f_l10);
            r_g_p[6] <= 64'(r_f_l11) * 64'(r_f_l11);
            r_g_p[7] <= 64'(r_f_l11) * 64'(r_f_l21);
        end
    end
    logic signed [63:0] r_g_hh;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_g_hh <= 64'(r_f_l21) * 64'(r_f_l21);
        end
    end

    // Stage H: sums, round, saturate.
    logic signed [31:0] r_h_cov [0:5];
    logic signed [63:0] w_s [0:5];
    assign w_s[0] = (r_g_p[0] + r_g_p[1] + 64'sd32768) >>> 16;
    assign w_s[1] = (r_g_p[2] + r_g_p[3] + 64'sd32768) >>> 16;
    assign w_s[2] = (r_g_p[4] + 64'sd32768) >>> 16;
    assign w_s[3] = (r_g_p[5] + r_g_p[6] + 64'sd32768) >>> 16;
    assign w_s[4] = (r_g_p[7] + 64'sd32768) >>> 16;
    assign w_s[5] = (r_g_hh + 64'sd32768) >>> 16;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 6; k++) begin
                r_h_cov[k] <= sat32(w_s[k]);
            end
        end
    end

    // Align delta fields with the covariance (D -> H is four stages).
    logic signed [23:0] r_dx [0:3], r_dy [0:3], r_dh [0:3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dx[0] <= r_d_dx;
            r_dy[0] <= r_d_dy;
            r_dh[0] <= r_d_dh;
            for (int k = 1; k < 4; k++) begin
                r_dx[k] <= r_dx[k-1];
                r_dy[k] <= r_dy[k-1];
                r_dh[k] <= r_dh[k-1];
            end
        end
    end

    // Output register: the pipe's last slot, zero-speed beats forced to zero.
    logic zf;
    assign zf = r_z[LT];
    assign o_valid = r_v[LT];
    always_comb begin
        o_data.delta_x      = zf ? '0 : r_dx[3];
        o_data.delta_y      = zf ? '0 : r_dy[3];
        o_data.heading_step = zf ? '0 : r_dh[3];
        o_data.cov_xx       = zf ? '0 : r_h_cov[0];
        o_data.cov_xy       = zf ? '0 : r_h_cov[1];
        o_data.cov_xh       = zf ? '0 : r_h_cov[2];
        o_data.cov_yy       = zf ? '0 : r_h_cov[3];
        o_data.cov_yh       = zf ? '0 : r_h_cov[4];
        o_data.cov_hh       = zf ? '0 : r_h_cov[5];
        o_data.tag_out      = r_tg[LT];
    end
endmodule

/* rtl/oekf_cordic.sv */
// Pipelined rotation-mode CORDIC: Q.29 angle in, Q.20 cosine and sine out.
module oekf_cordic (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [33:0] i_angle,
    output logic signed [21:0] o_cos,
    output logic signed [21:0] o_sin
);
    localparam int N = oekf_pkg::CordicRun;

    logic signed [33:0] r_x [0:N];
    logic signed [33:0] r_y [0:N];
    logic signed [33:0] r_z [0:N];
    logic               r_neg [0:N];
    logic signed [33:0] n_z1;
    logic signed [33:0] n_z2;
    logic               n_neg;
    logic signed [33:0] w_xf;
    logic signed [33:0] w_yf;
    logic signed [33:0] w_xr;
    logic signed [33:0] w_yr;

    // Reduce into [-pi, pi], then fold into [-pi/2, pi/2].
    always_comb begin
        n_z1 = i_angle;
        if (n_z1 > oekf_pkg::AngPi) begin
            n_z1 = n_z1 - oekf_pkg::AngTwoPi;
        end
        if (n_z1 < -oekf_pkg::AngPi) begin
            n_z1 = n_z1 + oekf_pkg::AngTwoPi;
        end
        n_neg = 1'b0;
        n_z2  = n_z1;
        if (n_z1 > oekf_pkg::AngHalfPi) begin
            n_z2 = n_z1 - oekf_pkg::AngPi;
            n_neg = 1'b1;
        end else if (n_z1 < -oekf_pkg::AngHalfPi) begin
            n_z2 = n_z1 + oekf_pkg::AngPi;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= 34'(oekf_pkg::CordicGain);
            r_y[0]   <= '0;
            r_z[0]   <= n_z2;
            r_neg[0] <= n_neg;
            for (int g = 0; g < N; g++) begin
                r_neg[g+1] <= r_neg[g];
                if (r_z[g] >= 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - oekf_pkg::atan_at(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + oekf_pkg::atan_at(g);
                end
            end
        end
    end

    assign w_xf = r_neg[N] ? -r_x[N] : r_x[N];
    assign w_yf = r_neg[N] ? -r_y[N] : r_y[N];
    assign w_xr = (w_xf + 34'sd512) >>> 10;
    assign w_yr = (w_yf + 34'sd512) >>> 10;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= w_xr[21:0];
            o_sin <= w_yr[21:0];
        end
    end
endmodule
